// File: design/slid_pkg.sv
// shared types and constants for the sorted list insert/delete table
package slid_pkg;

   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int COUNT_OUT_W     = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_DELETED  = 2'd1,
      ST_NOMATCH  = 2'd2,
      ST_FULL     = 2'd3
   } slid_status_type;

   // position flags one cell hands to its right neighbor
   typedef struct packed {
      logic ins_at;   // slot is at or after the insert point
      logic del_at;   // slot is occupied and holds a value >= request
   } slid_flags_type;

   // table update that applies to every cell in the cycle of a transfer
   typedef struct packed {
      logic do_ins;
      logic do_del;
   } slid_ctrl_type;

endpackage

// File: design/slid_cell.sv
// one slot of the sorted table: compare, then hold, load the request value, or shift left or right
module slid_cell #(
   parameter int INDEX       = 0,
   parameter int CNT_W       = 5,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic [VALUE_WIDTH-1:0]  value,
   input  logic [CNT_W-1:0]        count,
   input  slid_pkg::slid_ctrl_type ctrl,
   input  slid_pkg::slid_flags_type left_flags,
   input  logic [VALUE_WIDTH-1:0]  left_entry,
   input  logic [VALUE_WIDTH-1:0]  right_entry,
   output slid_pkg::slid_flags_type flags,
   output logic [VALUE_WIDTH-1:0]  entry,
   output logic                    hit
);
   import slid_pkg::*;

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   occupied;
   logic                   less;
   logic                   below;

   always_comb begin
      occupied     = count > CNT_W'(INDEX);
      less         = value < entry_ff;
      below        = entry_ff < value;
      flags.ins_at = !occupied || less;
      flags.del_at = occupied && !below;
      // first slot holding a value >= request, and it is equal
      hit          = flags.del_at && !left_flags.del_at && (entry_ff == value);
      entry_in     = entry_ff;
      if (ctrl.do_ins && flags.ins_at) begin
         entry_in = left_flags.ins_at ? left_entry : value;
      end else if (ctrl.do_del && flags.del_at) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: design/sorted_list_insert_delete.sv
// top level: chain of table slots with count, status and result register
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_type, req_item_value
//   rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_entry_count,
//           |           | rsp_table_full
//
// one request per cycle while req_stall is low; every slot compares and shifts in the cycle of the transfer,
// and the result shows in the output register on the next cycle.
// reset empties the table (count to zero) with no clearing pass.
// a stalled result holds req_stall high until it is taken; requests then wait.
module sorted_list_insert_delete #(
   parameter int CAPACITY    = slid_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = slid_pkg::DEF_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [VALUE_WIDTH-1:0]          req_item_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [slid_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                            rsp_table_full
);
   import slid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   slid_status_type        status_ff;
   slid_status_type        status_in;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic                   full_ff;

   logic                   accept;
   logic                   full;
   logic                   found;
   slid_ctrl_type          ctrl;
   logic [CAPACITY-1:0]    hits;
   logic [VALUE_WIDTH-1:0] entries [CAPACITY];
   slid_flags_type         flags   [CAPACITY];
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign found     = |hits;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slid_flags_type         lf;
      logic [VALUE_WIDTH-1:0] le;
      logic [VALUE_WIDTH-1:0] re;
      if (i == 0) begin : g_first
         assign lf = '0;
         assign le = entries[i];
      end else begin : g_mid
         assign lf = flags[i-1];
         assign le = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign re = entries[i];
      end else begin : g_notlast
         assign re = entries[i+1];
      end
      slid_cell #(
         .INDEX      (i),
         .CNT_W      (CNT_W),
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .value      (req_item_value),
         .count      (count_ff),
         .ctrl       (ctrl),
         .left_flags (lf),
         .left_entry (le),
         .right_entry(re),
         .flags      (flags[i]),
         .entry      (entries[i]),
         .hit        (hits[i])
      );
   end

   always_comb begin
      ctrl.do_ins = accept && (req_type == OP_INSERT) && !full;
      ctrl.do_del = accept && (req_type == OP_DELETE) && found;
      count_in    = count_ff;
      if (ctrl.do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (req_type == OP_INSERT) begin
         status_in = full ? ST_FULL : ST_INSERTED;
      end else begin
         status_in = found ? ST_DELETED : ST_NOMATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
         full_ff      <= count_in == CNT_W'(CAPACITY);
      end
   end

   assign count_ext       = {{COUNT_OUT_W{1'b0}}, rsp_count_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ext[COUNT_OUT_W-1:0];
   assign rsp_table_full  = full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hits))
      else $error("more than one slot matched a delete");

   a_rsp_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("no result after request transfer");

   a_dropped_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_FULL) |-> full_ff)
      else $error("insert dropped while table not full");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !ctrl.do_ins && !ctrl.do_del) |=> $stable(count_ff))
      else $error("count changed without a table update");

endmodule
